@@ rtl/qfs_pkg.sv @@
`timescale 1ns / 1ps

package qfs_pkg;

  localparam int unsigned NumDelimiters = 4;
  localparam int unsigned DelimIdxW     = $clog2(NumDelimiters);

  localparam logic [15:0] MaxStringLength = 16'hFFFF;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgDelimChar0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDelimChar1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDelimChar2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDelimChar3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxFields  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSkipEmpty  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOpenQuote  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgCloseQuote = 3'd7;

  localparam logic [7:0] NulChar = 8'h00;

  localparam logic [7:0] MaxFieldsReset = 8'd255;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic [7:0]  field_index;
    logic        field_present;
    logic        last_result;
    logic [7:0]  field_count;
  } out_item_t;

endpackage

@@ rtl/quoted_field_splitter_unit.sv @@
`timescale 1ns / 1ps

// Splits a byte string into fields at up to four configurable delimiter bytes, except
// inside an open/close quote span, and emits each field as start offset and length,
// followed by a terminal result carrying the kept field count. One byte is accepted
// per cycle unless the result queue holds more than two results: a byte is held in
// the input register, where all splitting logic runs, and its results land in a
// four-entry result queue that drives the output. A byte may produce up to two
// results, and the output port delivers one result per cycle while out_ready_i is
// high, so a stream in which most bytes end a field and a string is limited by the
// output port; otherwise throughput is one byte per cycle. Configuration writes are
// taken at any time and must only happen while the block is idle.
module quoted_field_splitter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qfs_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qfs_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [qfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  // configuration
  logic [7:0] delim_q [qfs_pkg::NumDelimiters];
  logic [7:0] max_fields_q;
  logic       skip_empty_q;
  logic [7:0] open_quote_q;
  logic [7:0] close_quote_q;

  // string state
  logic [15:0] pos_q, pos_d;
  logic [15:0] cur_start_q, cur_start_d;
  logic [7:0]  raw_cnt_q, raw_cnt_d;
  logic [7:0]  kept_cnt_q, kept_cnt_d;
  logic        in_quotes_q, in_quotes_d;

  // input register
  logic              in_vld_q;
  qfs_pkg::in_item_t in_item_q;

  // result queue
  qfs_pkg::out_item_t rq_mem_q [4];
  logic [1:0]         rq_wr_ptr_q;
  logic [1:0]         rq_rd_ptr_q;
  logic [2:0]         rq_cnt_q;

  logic process;
  logic pop;

  logic [7:0]  c;
  logic        nz;
  logic        eos;
  logic        start_new;
  logic [7:0]  raw1;
  logic [15:0] start1;
  logic        inq1;
  logic        active;
  logic        is_open;
  logic        is_close;
  logic        delim_hit;
  logic        split;
  logic [15:0] len1;
  logic        emit1;
  logic [7:0]  kept1;
  logic [7:0]  raw2;
  logic [15:0] start2;
  logic        inq2;
  logic [15:0] pos2;
  logic [15:0] len2;
  logic        emit2;
  logic [1:0]  n_push;

  qfs_pkg::out_item_t res1, res2, wr0;

  assign cfg_ready_o = 1'b1;

  assign process    = in_vld_q && (rq_cnt_q <= 3'd2);
  assign in_ready_o = !in_vld_q || process;
  assign pop        = out_valid_o && out_ready_i;

  assign out_valid_o = (rq_cnt_q != 3'd0);
  assign out_data_o  = rq_mem_q[rq_rd_ptr_q];

  always_comb begin
    c   = in_item_q.char_in;
    nz  = (c != qfs_pkg::NulChar);
    eos = in_item_q.end_of_string || !nz;

    start_new = nz && (raw_cnt_q == 8'd0) && (max_fields_q != 8'd0);
    raw1      = start_new ? 8'd1 : raw_cnt_q;
    start1    = start_new ? pos_q : cur_start_q;
    inq1      = start_new ? 1'b0 : in_quotes_q;

    active = nz && (raw1 != 8'd0) && (raw1 < max_fields_q);

    delim_hit = 1'b0;
    for (int i = 0; i < qfs_pkg::NumDelimiters; i++) begin
      if (delim_q[i] != qfs_pkg::NulChar && delim_q[i] == c) begin
        delim_hit = 1'b1;
      end
    end

    is_open  = !inq1 && (open_quote_q != qfs_pkg::NulChar) && (c == open_quote_q);
    is_close = inq1 && (c == close_quote_q);
    split    = active && !inq1 && !is_open && delim_hit;

    len1  = pos_q - start1;
    emit1 = split && !(skip_empty_q && (len1 == 16'd0));
    kept1 = kept_cnt_q + {7'd0, emit1};

    raw2 = raw1 + {7'd0, split};
    if (split) begin
      start2 = (pos_q != qfs_pkg::MaxStringLength) ? pos_q + 16'd1 : qfs_pkg::MaxStringLength;
    end else begin
      start2 = start1;
    end

    if (active && is_open) begin
      inq2 = 1'b1;
    end else if (active && is_close) begin
      inq2 = 1'b0;
    end else begin
      inq2 = inq1;
    end

    pos2 = (nz && pos_q != qfs_pkg::MaxStringLength) ? pos_q + 16'd1 : pos_q;

    len2  = pos2 - start2;
    emit2 = (raw2 != 8'd0) && !(skip_empty_q && (len2 == 16'd0));

    res1.field_start   = start1;
    res1.field_length  = len1;
    res1.field_index   = kept_cnt_q;
    res1.field_present = 1'b1;
    res1.last_result   = 1'b0;
    res1.field_count   = 8'd0;

    if (emit2) begin
      res2.field_start   = start2;
      res2.field_length  = len2;
      res2.field_index   = kept1;
      res2.field_present = 1'b1;
      res2.last_result   = 1'b1;
      res2.field_count   = kept1 + 8'd1;
    end else begin
      res2.field_start   = 16'd0;
      res2.field_length  = 16'd0;
      res2.field_index   = 8'd0;
      res2.field_present = 1'b0;
      res2.last_result   = 1'b1;
      res2.field_count   = kept1;
    end

    wr0    = emit1 ? res1 : res2;
    n_push = {1'b0, emit1} + {1'b0, eos};

    if (eos) begin
      pos_d       = 16'd0;
      cur_start_d = 16'd0;
      raw_cnt_d   = 8'd0;
      kept_cnt_d  = 8'd0;
      in_quotes_d = 1'b0;
    end else begin
      pos_d       = pos2;
      cur_start_d = start2;
      raw_cnt_d   = raw2;
      kept_cnt_d  = kept1;
      in_quotes_d = inq2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qfs_pkg::NumDelimiters; i++) begin
        delim_q[i] <= qfs_pkg::NulChar;
      end
      max_fields_q  <= qfs_pkg::MaxFieldsReset;
      skip_empty_q  <= 1'b0;
      open_quote_q  <= qfs_pkg::NulChar;
      close_quote_q <= qfs_pkg::NulChar;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qfs_pkg::CfgDelimChar0,
        qfs_pkg::CfgDelimChar1,
        qfs_pkg::CfgDelimChar2,
        qfs_pkg::CfgDelimChar3: begin
          delim_q[cfg_index_i[qfs_pkg::DelimIdxW-1:0]] <= cfg_data_i;
        end
        qfs_pkg::CfgMaxFields:  max_fields_q  <= cfg_data_i;
        qfs_pkg::CfgSkipEmpty:  skip_empty_q  <= cfg_data_i[0];
        qfs_pkg::CfgOpenQuote:  open_quote_q  <= cfg_data_i;
        qfs_pkg::CfgCloseQuote: close_quote_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 16'd0;
      cur_start_q <= 16'd0;
      raw_cnt_q   <= 8'd0;
      kept_cnt_q  <= 8'd0;
      in_quotes_q <= 1'b0;
    end else if (process) begin
      pos_q       <= pos_d;
      cur_start_q <= cur_start_d;
      raw_cnt_q   <= raw_cnt_d;
      kept_cnt_q  <= kept_cnt_d;
      in_quotes_q <= in_quotes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (process) begin
      if (n_push != 2'd0) begin
        rq_mem_q[rq_wr_ptr_q] <= wr0;
      end
      if (n_push == 2'd2) begin
        rq_mem_q[rq_wr_ptr_q + 2'd1] <= res2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_ptr_q <= 2'd0;
      rq_rd_ptr_q <= 2'd0;
      rq_cnt_q    <= 3'd0;
    end else begin
      if (process) begin
        rq_wr_ptr_q <= rq_wr_ptr_q + n_push;
      end
      if (pop) begin
        rq_rd_ptr_q <= rq_rd_ptr_q + 2'd1;
      end
      rq_cnt_q <= rq_cnt_q + (process ? {1'b0, n_push} : 3'd0) - {2'd0, pop};
    end
  end

endmodule
